// File: src/ffba_pkg.sv
package ffba_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 64;
    localparam int GRP_SIZE  = 8;
    localparam int GRP_BITS  = 3;
    localparam int NUM_GRP   = (POOL_SIZE + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W     = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
    localparam int SLOT_W    = GRP_W + GRP_BITS;
    localparam int MAP_SIZE  = 2 ** SLOT_W;

    // Operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_DOUBLE   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic       func;
        logic [7:0] slot_index;
    } t_req;

    typedef struct packed {
        logic [7:0] granted_slot;
        logic [1:0] status;
        logic [7:0] free_count;
    } t_res;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
    } t_dp_cmd;

endpackage

// File: src/ffba_ctrl.sv
module ffba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output ffba_pkg::t_dp_cmd o_cmd,
    output logic              o_valid
);
    import ffba_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_EXEC);
        end
    end

    // Commands to datapath
    assign busy       = (r_state != S_IDLE);
    assign o_cmd.load = start && (r_state == S_IDLE);
    assign o_cmd.scan = (r_state == S_SCAN);
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_valid    = r_valid;

endmodule

// File: src/ffba_dp.sv
module ffba_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffba_pkg::t_dp_cmd i_cmd,
    input  ffba_pkg::t_req    i_req,
    output ffba_pkg::t_res    o_res
);
    import ffba_pkg::*;

    logic [POOL_SIZE-1:0] r_marks;
    logic [7:0]           r_count;
    t_req                 r_req;
    t_res                 r_res;
    logic [NUM_GRP-1:0]   r_grp_free;
    logic [GRP_BITS-1:0]  r_grp_low [NUM_GRP];

    logic [MAP_SIZE-1:0]  w_map;
    logic [NUM_GRP-1:0]   n_grp_free;
    logic [GRP_BITS-1:0]  n_grp_low [NUM_GRP];

    logic                 w_found;
    logic [GRP_W-1:0]     w_grp;
    logic [SLOT_W-1:0]    w_slot;
    logic [SLOT_W-1:0]    w_idx;
    logic                 w_in_pool;
    logic [MAP_SIZE-1:0]  n_map;
    logic [POOL_SIZE-1:0] n_marks;
    logic [7:0]           n_count;
    t_res                 n_res;

    // Occupancy map, slots past the pool read as taken
    always_comb begin
        w_map                = '1;
        w_map[POOL_SIZE-1:0] = r_marks;
    end

    // First level: per-group free flag and lowest free bit
    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            n_grp_free[g] = ~&w_map[g*GRP_SIZE +: GRP_SIZE];
            n_grp_low[g]  = '0;
            for (int b = GRP_SIZE - 1; b >= 0; b--) begin
                if (!w_map[g*GRP_SIZE + b]) begin
                    n_grp_low[g] = GRP_BITS'(b);
                end
            end
        end
    end

    // Second level: lowest group with a free slot
    always_comb begin
        w_found = 1'b0;
        w_grp   = '0;
        for (int g = NUM_GRP - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                w_found = 1'b1;
                w_grp   = GRP_W'(g);
            end
        end
        w_slot = {w_grp, r_grp_low[w_grp]};
    end

    // Apply the operation
    always_comb begin
        w_idx     = r_req.slot_index[SLOT_W-1:0];
        w_in_pool = (r_req.slot_index < 8'(POOL_SIZE));
        n_map     = w_map;
        n_count   = r_count;
        n_res     = '0;
        if (r_req.func == FUNC_ALLOC) begin
            if (w_found) begin
                n_map[w_slot]      = 1'b1;
                n_count            = r_count - 8'd1;
                n_res.granted_slot = 8'(w_slot);
                n_res.status       = ST_OK;
            end else begin
                n_res.status = ST_EMPTY;
            end
        end else begin
            if (!w_in_pool) begin
                n_res.status = ST_NOTFOUND;
            end else if (!w_map[w_idx]) begin
                n_res.status = ST_DOUBLE;
            end else begin
                n_map[w_idx] = 1'b0;
                n_count      = r_count + 8'd1;
                n_res.status = ST_OK;
            end
        end
        n_marks          = n_map[POOL_SIZE-1:0];
        n_res.free_count = n_count;
    end

    // Pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
            r_count <= 8'(POOL_SIZE);
        end else if (i_cmd.exec) begin
            r_marks <= n_marks;
            r_count <= n_count;
        end
    end

    // Request, search and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.scan) begin
            r_grp_free <= n_grp_free;
            r_grp_low  <= n_grp_low;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// File: src/first_fit_bit_pool_allocator.sv
// A taken beat is registered, then the group scan and apply states run, and o_valid
// is registered from the apply state. A new request is taken only while not busy; busy covers the
// group scan and the apply state that picks the lowest group and updates the marks.
// Reset (synchronous, active low) frees every slot and sets the count to the
// pool size. Each result is shown for one cycle; the receiver cannot stall.
module first_fit_bit_pool_allocator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ffba_pkg::t_req i_req,
    output logic           o_valid,
    output ffba_pkg::t_res o_res
);
    import ffba_pkg::*;

    t_dp_cmd w_cmd;

    ffba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd),
        .o_valid (o_valid)
    );

    ffba_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_res   (o_res)
    );

    // Accepted beat is followed by its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##3 o_valid)
        else $error("result strobe missing after accepted beat");

    // Block is free again while the result is shown
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy during result strobe");

    // Free count never exceeds the pool
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.free_count <= 8'(POOL_SIZE)))
        else $error("free count beyond pool size");

    // Only a successful allocate grants a nonzero slot
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.status != ST_OK) |-> (o_res.granted_slot == 8'd0))
        else $error("granted slot set on error");

endmodule
